/* rtl/tpq_pkg.sv */
// ----------------------------------------------------------------------------
// tpq_pkg
// shared types, constants and codes of the threshold priority queue
// ----------------------------------------------------------------------------
package tpq_pkg;

  localparam int DEF_QUEUE_DEPTH   = 64;
  localparam int DEF_PRIORITY_BITS = 8;
  localparam int DEF_TAG_BITS      = 16;

  localparam int OP_W      = 2;
  localparam int PRIO_W    = 8;
  localparam int TAG_W     = 16;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 7;
  localparam int THR_W     = 9;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 40;

  localparam logic [THR_W-1:0] THR_RESET = 9'd4;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_HEAD_RD,
    S_HEAD_CAP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    set_status;
    status_t status_code;
    logic    clear_q;
    logic    rd_head;
    logic    pop;
    logic    rd_idx;
    logic    scan_adv;
    logic    start_shift;
    logic    rd_prev;
    logic    wr_shift;
    logic    place;
    logic    append;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic below_thr;
    logic idx_at_count;
    logic idx_at_pos;
    logic rd_lower;
    logic rd_equal;
    logic out_free;
  } stat_t;

endpackage

/* rtl/threshold_priority_queue.sv */
// ----------------------------------------------------------------------------
// threshold_priority_queue
// bounded priority queue of tagged entries with a fifo threshold
// ----------------------------------------------------------------------------
// Requests are taken one at a time and each gives one result on the master
// side. Entries live in a single-port-read circular memory. A remove reads
// the head, pops it and loads its result; a tail append, clear or flagged
// request loads its result straight after decode; a sorted insert scans the
// entries from the head until one has a lower priority or the scan runs past
// the tail, then moves each entry from the tail down to that slot one slot
// toward the tail and places the new entry there; every read of that memory
// is registered before its data can be compared or written back. A result
// that is not taken holds the next request after it is decoded.
module threshold_priority_queue import tpq_pkg::*; #(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
  parameter int TAG_BITS      = DEF_TAG_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // op, priority_req, entry_tag, zero pad
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // status, removed_tag, removed_priority,
                                      // equal_ahead, occupancy
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [THR_W-1:0] cfg_data   // fifo_threshold
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  tpq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tpq_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS),
    .TAG_BITS      (TAG_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* rtl/tpq_ctrl.sv */
// ----------------------------------------------------------------------------
// tpq_ctrl
// sequencer for decode, head scan, entry shift and result hand-off
// ----------------------------------------------------------------------------
module tpq_ctrl import tpq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  s_tvalid,
  output logic  s_tready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.status_code = ST_OK;
    s_tready        = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (stat.op)
          OP_INSERT: begin
            if (stat.full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_FULL;
              state_next      = S_OUT;
            end else if (stat.empty || stat.below_thr) begin
              cmd.append = 1'b1;
              state_next = S_OUT;
            end else begin
              state_next = S_SCAN_RD;
            end
          end
          OP_REMOVE: begin
            if (stat.empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = ST_EMPTY;
              state_next      = S_OUT;
            end else begin
              state_next = S_HEAD_RD;
            end
          end
          OP_CLEAR: begin
            cmd.clear_q = 1'b1;
            state_next  = S_OUT;
          end
          default: begin
            state_next = S_OUT;
          end
        endcase
      end
      S_HEAD_RD: begin
        cmd.rd_head = 1'b1;
        state_next  = S_HEAD_CAP;
      end
      S_HEAD_CAP: begin
        cmd.pop    = 1'b1;
        state_next = S_OUT;
      end
      S_SCAN_RD: begin
        if (stat.idx_at_count) begin
          cmd.start_shift = 1'b1;
          state_next      = S_SHIFT_RD;
        end else begin
          cmd.rd_idx = 1'b1;
          state_next = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (stat.rd_lower) begin
          cmd.start_shift = 1'b1;
          state_next      = S_SHIFT_RD;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat.idx_at_pos) begin
          state_next = S_PLACE;
        end else begin
          cmd.rd_prev = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.wr_shift = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/tpq_datapath.sv */
// ----------------------------------------------------------------------------
// tpq_datapath
// circular slot memory, pointers, counters, threshold and result register
// ----------------------------------------------------------------------------
module tpq_datapath import tpq_pkg::*; #(
  parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH,
  parameter int PRIORITY_BITS = DEF_PRIORITY_BITS,
  parameter int TAG_BITS      = DEF_TAG_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             cfg_valid,
  input  logic [THR_W-1:0] cfg_data,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  localparam int PW = (PRIORITY_BITS < PRIO_W) ? PRIORITY_BITS : PRIO_W;
  localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int EW = PW + TW;
  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + 1;

  logic [THR_W-1:0] thr;
  logic [AW-1:0]    head;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    pos;
  logic [CW-1:0]    eq;
  op_t              req_op;
  logic [PW-1:0]    req_prio;
  logic [TW-1:0]    req_tag;
  status_t          res_status;
  logic [TW-1:0]    res_tag;
  logic [PW-1:0]    res_prio;
  logic [EW-1:0]    mem [QUEUE_DEPTH];
  logic [EW-1:0]    rd_data;
  logic [PW-1:0]    rd_prio;
  logic [CW-1:0]    rd_i;
  logic [CW-1:0]    wr_i;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;
  logic [EW-1:0]    wr_data;

  // logical slot to physical address, wrapping past the end
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [CW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(i);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign rd_prio = rd_data[EW-1:TW];

  always_comb begin
    if (cmd.rd_head) begin
      rd_i = '0;
    end else if (cmd.rd_prev) begin
      rd_i = idx - 1'b1;
    end else begin
      rd_i = idx;
    end
    if (cmd.place) begin
      wr_i = pos;
    end else if (cmd.append) begin
      wr_i = count;
    end else begin
      wr_i = idx;
    end
    rd_addr = phys(head, rd_i);
    wr_addr = phys(head, wr_i);
    wr_en   = cmd.place | cmd.append | cmd.wr_shift;
    wr_data = cmd.wr_shift ? rd_data : {req_prio, req_tag};
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_head || cmd.rd_idx || cmd.rd_prev) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    stat.op           = req_op;
    stat.empty        = (count == '0);
    stat.full         = (count == CW'(QUEUE_DEPTH));
    stat.below_thr    = (THR_W'(req_prio) < thr);
    stat.idx_at_count = (idx == count);
    stat.idx_at_pos   = (idx == pos);
    stat.rd_lower     = (rd_prio < req_prio);
    stat.rd_equal     = (rd_prio == req_prio);
    stat.out_free     = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_valid) begin
      thr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      if (cmd.clear_q) begin
        head  <= '0;
        count <= '0;
      end else if (cmd.pop) begin
        head  <= (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
        count <= count - 1'b1;
      end else if (cmd.place || cmd.append) begin
        count <= count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_op     <= op_t'(s_tdata[OP_W-1:0]);
      req_prio   <= s_tdata[OP_W +: PW];
      req_tag    <= s_tdata[OP_W + PRIO_W +: TW];
      idx        <= '0;
      eq         <= '0;
      res_status <= ST_OK;
      res_tag    <= '0;
      res_prio   <= '0;
    end else begin
      if (cmd.set_status) begin
        res_status <= cmd.status_code;
      end
      if (cmd.pop) begin
        res_tag  <= rd_data[TW-1:0];
        res_prio <= rd_prio;
      end
      if (cmd.scan_adv) begin
        idx <= idx + 1'b1;
        if (stat.rd_equal) begin
          eq <= eq + 1'b1;
        end
      end
      if (cmd.start_shift) begin
        pos <= idx;
        idx <= count;
      end
      if (cmd.wr_shift) begin
        idx <= idx - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {CNT_OUT_W'(count), CNT_OUT_W'(eq), PRIO_W'(res_prio), TAG_W'(res_tag),
                  res_status};
    end
  end

endmodule

/* rtl/tpq_checker.sv */
// ----------------------------------------------------------------------------
// tpq_checker
// port-level checks of the threshold priority queue
// ----------------------------------------------------------------------------
module tpq_checker import tpq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(QUEUE_DEPTH);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // remove on empty reports an empty queue and no entry
  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_EMPTY |->
      m_tdata[39:33] == '0 && m_tdata[25:2] == '0)
    else $error("bad remove-on-empty result");

  // insert on full reports a full queue and no equal count
  a_full_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == ST_FULL |->
      m_tdata[39:33] == FULL_CNT && m_tdata[32:26] == '0)
    else $error("bad insert-on-full result");

  // removed fields are only set together with an ok status
  a_removed_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[25:2] != '0 |-> m_tdata[1:0] == ST_OK)
    else $error("removed entry with error status");

endmodule

bind threshold_priority_queue tpq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_tpq_checker (.*);

/* test/threshold_priority_queue_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// threshold_priority_queue_tb
// checks insert, remove and clear results of the threshold priority queue
// against a queue-based copy of its behavior, over a sweep of thresholds,
// random idle gaps on both stream sides and long result back-pressure
// ----------------------------------------------------------------------------
module threshold_priority_queue_tb import tpq_pkg::*;;

  localparam int DEPTH        = DEF_QUEUE_DEPTH;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 150;
  localparam int LONG_HOLD    = 400;

  typedef struct packed {
    logic [IN_W-OP_W-PRIO_W-TAG_W-1:0] pad;
    logic [TAG_W-1:0]                  tag;
    logic [PRIO_W-1:0]                 prio;
    logic [OP_W-1:0]                   op;
  } request_t;

  typedef struct packed {
    logic [CNT_OUT_W-1:0] occupancy;
    logic [CNT_OUT_W-1:0] equal_ahead;
    logic [PRIO_W-1:0]    removed_priority;
    logic [TAG_W-1:0]     removed_tag;
    logic [STATUS_W-1:0]  status;
  } result_t;

  logic             clk;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  request_t         s_tdata;
  logic             m_tvalid;
  logic             m_tready;
  result_t          m_tdata;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [THR_W-1:0] cfg_data;

  // queue contents as the block should hold them, head first
  logic [PRIO_W-1:0] held_prio[$];
  logic [TAG_W-1:0]  held_tag[$];
  logic [THR_W-1:0]  fifo_thr = THR_RESET;

  request_t req_backlog[$];
  result_t  due_results[$];
  int       queued_total  = 0;
  int       accepted_reqs = 0;
  int       results_seen  = 0;
  int       errors        = 0;
  int       quiet_cycles  = 0;
  int       tx_gap        = 0;
  int       rx_hold       = 0;
  bit       gaps_on       = 1'b1;

  threshold_priority_queue i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t queue_apply(request_t rq);
    result_t rs;
    int      pos;
    rs  = '0;
    pos = 0;
    case (op_t'(rq.op))
      OP_INSERT: begin
        if (held_prio.size() >= DEPTH) begin
          rs.status = ST_FULL;
        end else if (held_prio.size() == 0 || rq.prio < fifo_thr) begin
          held_prio.push_back(rq.prio);
          held_tag.push_back(rq.tag);
        end else begin
          while (pos < held_prio.size() && held_prio[pos] >= rq.prio) begin
            if (held_prio[pos] == rq.prio) rs.equal_ahead = rs.equal_ahead + 1'b1;
            pos++;
          end
          held_prio.insert(pos, rq.prio);
          held_tag.insert(pos, rq.tag);
        end
      end
      OP_REMOVE: begin
        if (held_prio.size() == 0) begin
          rs.status = ST_EMPTY;
        end else begin
          rs.removed_priority = held_prio.pop_front();
          rs.removed_tag      = held_tag.pop_front();
        end
      end
      OP_CLEAR: begin
        held_prio.delete();
        held_tag.delete();
      end
      default: ;
    endcase
    rs.occupancy = CNT_OUT_W'(held_prio.size());
    return rs;
  endfunction

  function automatic int idle_len(bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [PRIO_W-1:0] pick_priority();
    int v;
    case ($urandom_range(0, 5))
      0, 1:    v = $urandom_range(0, 7);
      2:       v = int'(fifo_thr) + int'($urandom_range(0, 2)) - 1;
      3:       v = $urandom_range(0, 1) ? 255 : 0;
      default: v = $urandom_range(0, 255);
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[PRIO_W-1:0];
  endfunction

  task automatic add_request(logic [OP_W-1:0] op, logic [PRIO_W-1:0] p,
                             logic [TAG_W-1:0] t);
    request_t rq;
    rq      = '0;
    rq.op   = op;
    rq.prio = p;
    rq.tag  = t;
    req_backlog.push_back(rq);
    queued_total++;
  endtask

  // batches that mostly fill, mostly drain, or mix
  task automatic add_random(int count);
    int               left;
    int               batch;
    int               mode;
    int               r;
    logic [OP_W-1:0]  op;
    left = count;
    while (left > 0) begin
      mode  = $urandom_range(0, 2);
      batch = (mode == 0) ? $urandom_range(60, 140) : $urandom_range(30, 100);
      if (batch > left) batch = left;
      left -= batch;
      repeat (batch) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: op = (r < 85) ? OP_INSERT : (r < 97) ? OP_REMOVE : (r < 99) ? OP_NOP : OP_CLEAR;
          1: op = (r < 20) ? OP_INSERT : (r < 96) ? OP_REMOVE : (r < 98) ? OP_NOP : OP_CLEAR;
          default: op = (r < 55) ? OP_INSERT : (r < 93) ? OP_REMOVE :
                        (r < 97) ? OP_NOP : OP_CLEAR;
        endcase
        add_request(op, pick_priority(), TAG_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic wait_idle();
    while (accepted_reqs != queued_total || due_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    fifo_thr = value;
  endtask

  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (due_results.size() == 0) begin
      $display("%0t: unexpected result, expected none actual %h", $time, got);
      errors++;
    end else begin
      want = due_results.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("removed_tag", want.removed_tag, got.removed_tag);
      cmp_field("removed_priority", want.removed_priority, got.removed_priority);
      cmp_field("equal_ahead", want.equal_ahead, got.equal_ahead);
      cmp_field("occupancy", want.occupancy, got.occupancy);
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        due_results.push_back(queue_apply(s_tdata));
        accepted_reqs++;
      end
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          s_tdata  <= req_backlog.pop_front();
          s_tvalid <= 1'b1;
          tx_gap = idle_len(gaps_on);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        check_result(m_tdata);
        results_seen++;
      end
      if (m_tvalid && m_tready && (results_seen == 300 || results_seen == 1100)) begin
        rx_hold = LONG_HOLD;
        m_tready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_hold = idle_len(gaps_on);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int thr_list[6];
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    thr_list  = '{0, 256, 255, 1, $urandom_range(2, 254), 4};

    // directed requests at the reset threshold
    add_request(OP_REMOVE, 8'd0, 16'h0000);
    add_request(OP_CLEAR, 8'd0, 16'h0000);
    add_request(OP_NOP, 8'd0, 16'h0000);
    add_request(OP_INSERT, 8'd200, 16'h0001);
    add_request(OP_INSERT, 8'd3, 16'hffff);
    add_request(OP_INSERT, 8'd255, 16'h8000);
    add_request(OP_INSERT, 8'd255, 16'h7fff);
    add_request(OP_INSERT, 8'd4, 16'h0000);
    add_request(OP_INSERT, 8'd200, 16'h1234);
    add_request(OP_INSERT, 8'd0, 16'h5555);
    add_request(OP_INSERT, 8'd255, 16'haaaa);
    add_request(OP_NOP, 8'd255, 16'hffff);
    repeat (4) add_request(OP_REMOVE, 8'd0, 16'h0000);
    add_request(OP_CLEAR, 8'd255, 16'hffff);
    add_request(OP_REMOVE, 8'd0, 16'h0000);
    add_request(OP_INSERT, 8'd255, 16'hffff);
    add_request(OP_REMOVE, 8'd0, 16'h0000);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    add_random(250);
    foreach (thr_list[i]) begin
      write_threshold(THR_W'(thr_list[i]));
      gaps_on = (i != 3);
      add_random(250);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/tpq_pkg.sv
rtl/tpq_ctrl.sv
rtl/tpq_datapath.sv
rtl/threshold_priority_queue.sv
rtl/tpq_checker.sv
test/threshold_priority_queue_tb.sv
